// ===== rtl/lbpd_pkg.sv =====
// shared types and constants for the buffer pool frame directory
// no dependencies; used by every module of the block
package lbpd_pkg;

    localparam int PAGE_W    = 31;
    localparam int STAMP_W   = 32;
    localparam int FRAME_O_W = 6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // one frame entry as held in the directory memory
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // outcome of a scan over the resident frames
    typedef struct packed {
        logic              found;
        logic              hit_dirty;
        logic              old_dirty;
        logic [PAGE_W-1:0] old_page;
    } t_scan_res;

endpackage

// ===== rtl/lru_buffer_pool_directory_top.sv =====
// top level of the buffer pool frame directory with lru replacement
// depends on lbpd_pkg, lbpd_frame_mem and lbpd_scan
//
// An access is a transfer taken when start is high and busy is low. The block
// scans the resident frames one per cycle out of a single-port-read memory,
// then writes the chosen frame back in the update state. Each frame in use
// (at most NUM_FRAMES) is read through the registered read port and its entry
// folded into the scan result; while the pool is still empty there is nothing
// to read and the block goes straight on to the update. The result appears on
// the o_ ports for exactly one cycle with o_valid high and cannot be held off;
// busy is already low in that cycle, so a new access may be started alongside.
// Frames fill in order from zero and are never released, so a fill count
// stands for the per-frame valid bits and no clearing pass is needed at reset.
module lru_buffer_pool_directory_top #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [lbpd_pkg::PAGE_W-1:0]         i_page_number,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [lbpd_pkg::FRAME_O_W-1:0]      o_frame_index,
    output logic                                o_writeback,
    output logic [lbpd_pkg::PAGE_W-1:0]         o_writeback_page
);
    import lbpd_pkg::*;

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [AW:0] FILL_FULL = (AW+1)'(NUM_FRAMES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [PAGE_W-1:0]   r_page;
    logic [STAMP_W-1:0]  r_counter;
    logic [AW:0]         r_fill;
    logic [AW:0]         r_addr;
    logic                r_pend;
    logic [AW-1:0]       r_pidx;
    logic                r_valid;
    logic                r_hit;
    logic [FRAME_O_W-1:0] r_frame;
    logic                r_wb;
    logic [PAGE_W-1:0]   r_wb_page;

    logic                accept;
    logic                rd_en;
    t_entry              rdata;
    t_entry              wdata;
    t_scan_res           res;
    logic [AW-1:0]       hit_idx;
    logic [AW-1:0]       old_idx;
    logic                full;
    logic [AW-1:0]       chosen;
    logic                wb_now;
    logic [AW+FRAME_O_W-1:0] chosen_ext;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // read the resident frames in order, one per cycle
    assign rd_en = (r_state == S_SCAN) && (r_addr < r_fill);

    // decision for the update cycle
    assign full   = (r_fill == FILL_FULL);
    assign wb_now = !res.found && full && res.old_dirty;

    always_comb begin
        if (res.found) begin
            chosen = hit_idx;
        end else if (!full) begin
            chosen = r_fill[AW-1:0];
        end else begin
            chosen = old_idx;
        end
    end

    // frame index reported as its low bits, zero-extended for small pools
    assign chosen_ext = {{FRAME_O_W{1'b0}}, chosen};

    always_comb begin
        wdata.page  = r_page;
        wdata.dirty = (r_op == OP_WRITE) || (res.found && res.hit_dirty);
        wdata.stamp = r_counter;
    end

    lbpd_frame_mem #(
        .DEPTH (NUM_FRAMES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_UPDATE),
        .i_waddr (chosen),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    lbpd_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (accept),
        .i_sample   (r_pend),
        .i_idx      (r_pidx),
        .i_entry    (rdata),
        .i_req_page (r_page),
        .i_counter  (r_counter),
        .o_res      (res),
        .o_hit_idx  (hit_idx),
        .o_old_idx  (old_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_counter <= '0;
            r_fill    <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            // result strobe follows the update cycle only
            r_valid <= (r_state == S_UPDATE);
            r_pend  <= rd_en;
            r_pidx  <= r_addr[AW-1:0];
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_op;
                        r_page  <= i_page_number;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_addr <= r_addr + 1'b1;
                    end else if (!r_pend) begin
                        // last entry has been folded into the scan result
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_counter <= r_counter + 1'b1;
                    if (!res.found && !full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_hit     <= res.found;
                    r_frame   <= chosen_ext[FRAME_O_W-1:0];
                    r_wb      <= wb_now;
                    r_wb_page <= wb_now ? res.old_page : '0;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_hit            = r_hit;
    assign o_frame_index    = r_frame;
    assign o_writeback      = r_wb;
    assign o_writeback_page = r_wb_page;

endmodule

// ===== rtl/lbpd_frame_mem.sv =====
// frame directory memory: one write port, one registered read port
// depends on lbpd_pkg for the entry type
module lbpd_frame_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  lbpd_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output lbpd_pkg::t_entry o_rdata
);
    import lbpd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lbpd_scan.sv =====
// scan unit: takes one frame entry a cycle while i_sample is high, tracks the hit and the oldest frame
// depends on lbpd_pkg for entry and result types
module lbpd_scan #(
    parameter int AW = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_sample,
    input  logic [AW-1:0]                i_idx,
    input  lbpd_pkg::t_entry             i_entry,
    input  logic [lbpd_pkg::PAGE_W-1:0]  i_req_page,
    input  logic [lbpd_pkg::STAMP_W-1:0] i_counter,
    output lbpd_pkg::t_scan_res          o_res,
    output logic [AW-1:0]                o_hit_idx,
    output logic [AW-1:0]                o_old_idx
);
    import lbpd_pkg::*;

    t_scan_res           r_res;
    logic [AW-1:0]       r_hit_idx;
    logic [AW-1:0]       r_old_idx;
    logic [STAMP_W-1:0]  r_best_age;
    logic [STAMP_W-1:0]  age;
    logic                is_hit;
    logic                is_older;

    // age survives counter wrap by modular difference
    assign age      = i_counter - i_entry.stamp;
    assign is_hit   = !r_res.found && (i_entry.page == i_req_page);
    assign is_older = (i_idx == '0) || (age > r_best_age);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_res      <= '0;
            r_hit_idx  <= '0;
            r_old_idx  <= '0;
            r_best_age <= '0;
        end else if (i_sample) begin
            if (is_hit) begin
                r_res.found     <= 1'b1;
                r_res.hit_dirty <= i_entry.dirty;
                r_hit_idx       <= i_idx;
            end
            if (is_older) begin
                r_best_age      <= age;
                r_old_idx       <= i_idx;
                r_res.old_dirty <= i_entry.dirty;
                r_res.old_page  <= i_entry.page;
            end
        end
    end

    assign o_res     = r_res;
    assign o_hit_idx = r_hit_idx;
    assign o_old_idx = r_old_idx;

endmodule

// ===== rtl/lbpd_checker.sv =====
// port-level checks for the buffer pool frame directory, bound to the top level
// depends on lbpd_pkg for field widths
module lbpd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           o_valid,
    input  logic                           o_hit,
    input  logic                           o_writeback,
    input  logic [lbpd_pkg::PAGE_W-1:0]    o_writeback_page
);
    import lbpd_pkg::*;

    // result strobe comes with the block free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transfer keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accept not followed by busy");

    // no write-back on a hit
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> !o_writeback)
        else $error("write-back reported on a hit");

    // write-back page is zero when there is no write-back
    a_wb_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback) |-> (o_writeback_page == '0))
        else $error("write-back page not zero");

endmodule

bind lru_buffer_pool_directory_top lbpd_checker u_lbpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_hit            (o_hit),
    .o_writeback      (o_writeback),
    .o_writeback_page (o_writeback_page)
);

// ===== bench/tb_lru_buffer_pool_directory_top.sv =====
// testbench for the lru frame directory of the buffer pool
// depends on lbpd_pkg and lru_buffer_pool_directory_top; self-checking, no files read
`timescale 1ns / 1ps

module tb_lru_buffer_pool_directory_top;
    import lbpd_pkg::*;

    localparam int FRAMES    = 64;
    localparam int POOL_SIZE = 96;

    // one result transfer as seen on the o_ ports
    typedef struct packed {
        logic                 hit;
        logic [FRAME_O_W-1:0] frame;
        logic                 wb;
        logic [PAGE_W-1:0]    wb_page;
    } t_access_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_op = OP_READ;
    logic [PAGE_W-1:0]    i_page_number = '0;
    logic                 o_valid;
    logic                 o_hit;
    logic [FRAME_O_W-1:0] o_frame_index;
    logic                 o_writeback;
    logic [PAGE_W-1:0]    o_writeback_page;

    lru_buffer_pool_directory_top #(
        .NUM_FRAMES(FRAMES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_writeback     (o_writeback),
        .o_writeback_page(o_writeback_page)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow copy of the frame directory, reset state is all zero
    bit                 dir_valid [FRAMES];
    bit [PAGE_W-1:0]    dir_page  [FRAMES];
    bit                 dir_dirty [FRAMES];
    bit [STAMP_W-1:0]   dir_stamp [FRAMES];
    bit [STAMP_W-1:0]   touch_count;

    // outcomes of accepted accesses, oldest first
    t_access_outcome    awaited_outcomes [$];

    int  accesses_sent   = 0;
    int  results_seen    = 0;
    int  hits_seen       = 0;
    int  writebacks_seen = 0;
    int  mismatch_count  = 0;
    bit  gaps_allowed    = 1'b1;

    // look up one page in the shadow directory and apply the access to it
    function automatic t_access_outcome lru_lookup(input logic op, input logic [PAGE_W-1:0] pg);
        t_access_outcome  res;
        bit               found;
        bit               have_free;
        int               hit_f;
        int               free_f;
        int               old_f;
        int               f;
        bit [STAMP_W-1:0] age;
        bit [STAMP_W-1:0] old_age;
        found = 1'b0;
        have_free = 1'b0;
        hit_f = 0;
        free_f = 0;
        old_f = 0;
        old_age = '0;
        res = '0;
        // one pass finds the hit, the lowest free frame and the oldest resident
        for (int i = 0; i < FRAMES; i++) begin
            if (dir_valid[i]) begin
                // age is modulo 2^32 so the ordering survives counter wrap
                age = touch_count - dir_stamp[i];
                if (!found && dir_page[i] == pg) begin
                    found = 1'b1;
                    hit_f = i;
                end
                // ties go to the lowest index
                if (i == 0 || age > old_age) begin
                    old_age = age;
                    old_f = i;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_f = i;
            end
        end
        if (found) begin
            f = hit_f;
            // read hit leaves the dirty bit alone
            if (op == OP_WRITE) dir_dirty[f] = 1'b1;
        end else begin
            f = have_free ? free_f : old_f;
            if (dir_valid[f] && dir_dirty[f]) begin
                res.wb = 1'b1;
                res.wb_page = dir_page[f];
            end
            dir_valid[f] = 1'b1;
            dir_page[f] = pg;
            dir_dirty[f] = (op == OP_WRITE);
        end
        dir_stamp[f] = touch_count;
        touch_count = touch_count + 1;
        res.hit = found;
        res.frame = FRAME_O_W'(f);
        return res;
    endfunction

    function automatic int frames_in_use();
        int n;
        n = 0;
        foreach (dir_valid[i]) n += dir_valid[i];
        return n;
    endfunction

    function automatic logic any_op();
        return $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    endfunction

    function automatic string describe(input t_access_outcome o);
        return $sformatf("hit=%0b frame=%0d writeback=%0b writeback_page=%h",
                         o.hit, o.frame, o.wb, o.wb_page);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // one access transfer: optional idle gap, then hold start until busy is low
    // start stays high on return so back-to-back transfers need no extra step
    task automatic send_access(input logic op, input logic [PAGE_W-1:0] pg);
        int gap;
        if (gaps_allowed && $urandom_range(0, 99) < 29) begin
            // short gaps and gaps as long as a full scan, so the restart
            // lands on every phase of the block's work
            gap = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, FRAMES + 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_page_number <= pg;
        do @(posedge i_clk); while (busy !== 1'b0);
        awaited_outcomes.push_back(lru_lookup(op, pg));
        accesses_sent++;
    endtask

    // result checker: the strobe lasts one cycle and cannot be held off
    always @(posedge i_clk) begin
        t_access_outcome seen;
        t_access_outcome want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            seen = {o_hit, o_frame_index, o_writeback, o_writeback_page};
            results_seen++;
            if (seen.hit === 1'b1) hits_seen++;
            if (seen.wb === 1'b1) writebacks_seen++;
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch({"result with nothing outstanding: ", describe(seen)});
            end else begin
                want = awaited_outcomes.pop_front();
                if (seen !== want)
                    flag_mismatch({"expected ", describe(want), " got ", describe(seen)});
            end
        end
    end

    // page extremes, alternating bit patterns, every op on hit and miss
    task automatic test_extremes();
        send_access(OP_READ,  31'h0000_0000);   // miss into the first free frame
        send_access(OP_WRITE, 31'h7FFF_FFFF);   // write miss leaves frame dirty
        send_access(OP_READ,  31'h0000_0000);   // read hit on a clean frame
        send_access(OP_WRITE, 31'h0000_0000);   // write hit dirties it
        send_access(OP_READ,  31'h7FFF_FFFF);   // read hit keeps dirty bit
        send_access(OP_WRITE, 31'h5555_5555);
        send_access(OP_READ,  31'h2AAA_AAAA);
        send_access(OP_READ,  31'h0000_0001);
        send_access(OP_WRITE, 31'h4000_0000);
        send_access(OP_WRITE, 31'h5555_5555);
        send_access(OP_READ,  31'h3FFF_FFFF);
        send_access(OP_READ,  31'h2AAA_AAAA);
    endtask

    // fill every frame, then refresh frame zero and evict the next oldest
    task automatic test_fill_and_evict();
        while (frames_in_use() < FRAMES) send_access(any_op(), PAGE_W'($urandom));
        send_access(OP_READ, dir_page[0]);
        repeat (4) send_access(any_op(), PAGE_W'($urandom));
    endtask

    // one page more than there are frames, in a loop: every access misses
    // and each dirty victim comes back as a write-back
    task automatic test_lru_cycle();
        logic [PAGE_W-1:0] base;
        base = PAGE_W'($urandom);
        for (int lap = 0; lap < 2; lap++) begin
            for (int i = 0; i <= FRAMES; i++)
                send_access(any_op(), base + PAGE_W'(i * 7919));
        end
    endtask

    // random accesses from a working set whose size moves about the frame count,
    // with fully random pages and corner patterns as noise
    task automatic test_random_mix(input int n_items);
        logic [PAGE_W-1:0] pool [POOL_SIZE];
        logic [PAGE_W-1:0] pg;
        int                hot;
        int                r;
        foreach (pool[i]) pool[i] = PAGE_W'($urandom);
        hot = 48;
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0) hot = $urandom_range(8, POOL_SIZE);
            // long run of back-to-back transfers in the middle
            gaps_allowed = !(k >= 250 && k < 450);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                pg = PAGE_W'($urandom);
            end else if (r < 18) begin
                case ($urandom_range(0, 3))
                    0: pg = '0;
                    1: pg = '1;
                    2: pg = PAGE_W'(1) << $urandom_range(0, PAGE_W - 1);
                    default: pg = ~(PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
                endcase
            end else begin
                // now and then swap a working-set entry for a fresh page
                if (r < 22) pool[$urandom_range(0, hot - 1)] = PAGE_W'($urandom);
                pg = pool[$urandom_range(0, hot - 1)];
            end
            send_access(any_op(), pg);
        end
        gaps_allowed = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_fill_and_evict();
        test_lru_cycle();
        test_random_mix(750);

        // let the last transfers complete, then allow a full scan for strays
        start <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (FRAMES + 8) @(posedge i_clk);

        if (awaited_outcomes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

        $display("covered %0d accesses over %0d frames: %0d results, %0d hits, %0d write-backs",
                 accesses_sent, FRAMES, results_seen, hits_seen, writebacks_seen);
        $display("free-frame fill, lru eviction under thrash and random working sets; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("watchdog expired with %0d results outstanding", awaited_outcomes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
